[rtl/core/hsj_pkg.sv]
// Package for the hexahedron shape function and Jacobian block.
// Shared widths, limits, controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps

package hsj_pkg;

	localparam int DEF_POINT_FRAC_BITS = 14;

	// field widths
	localparam int NODE_W  = 3;
	localparam int PT_W    = 16;
	localparam int CRD_W   = 16;
	localparam int OUT_W   = 18;
	localparam int DET_W   = 51;

	// Jacobian sums and determinant arithmetic
	localparam int JW      = 40;
	localparam int MAW     = 2 * JW + 2;   // minor difference operand
	localparam int MBW     = JW;
	localparam int MPW     = MAW + MBW;
	localparam int MDIG    = 8;            // multiplier digit per cycle
	localparam int MSTEPS  = MBW / MDIG;
	localparam int ACCW    = MPW + 2;
	localparam int DET_FRAC = 48;
	localparam int STEP_W  = 4;
	localparam int DET_STEPS = 9;

	localparam logic signed [79:0] OUT_MAX = 80'sd131071;
	localparam logic signed [79:0] OUT_MIN = -80'sd131072;

	typedef struct packed {
		logic              latch;
		logic              prod;
		logic              deriv;
		logic              jac;
		logic              det_start;
		logic              det_apply;
		logic              det_fin;
		logic              load_out;
		logic [STEP_W-1:0] det_step;
	} cmd_t;

	typedef struct packed {
		logic node7;
		logic mul_done;
	} status_t;

	// clamp a wide signed value to the 18 bit output range
	function automatic logic signed [OUT_W-1:0] sat18(input logic signed [79:0] v);
		logic signed [79:0] r;
		if (v > OUT_MAX) r = OUT_MAX;
		else if (v < OUT_MIN) r = OUT_MIN;
		else r = v;
		return r[OUT_W-1:0];
	endfunction

endpackage

[rtl/core/hsj_in_if.sv]
// Request channel for one hexahedron node: valid/ready plus node payload.
// Depends on hsj_pkg for field widths.
`timescale 1ns / 1ps

interface hsj_in_if;
	import hsj_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [NODE_W-1:0]        node_index;
	logic signed [PT_W-1:0]   point_xi;
	logic signed [PT_W-1:0]   point_eta;
	logic signed [PT_W-1:0]   point_zeta;
	logic signed [CRD_W-1:0]  node_x;
	logic signed [CRD_W-1:0]  node_y;
	logic signed [CRD_W-1:0]  node_z;

	modport source (output valid, node_index, point_xi, point_eta, point_zeta,
		node_x, node_y, node_z, input ready);
	modport sink (input valid, node_index, point_xi, point_eta, point_zeta,
		node_x, node_y, node_z, output ready);
endinterface

[rtl/core/hsj_out_if.sv]
// Result channel: shape value, natural derivatives and determinant.
// Depends on hsj_pkg for field widths.
`timescale 1ns / 1ps

interface hsj_out_if;
	import hsj_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [NODE_W-1:0]        result_node;
	logic signed [OUT_W-1:0]  shape_value;
	logic signed [OUT_W-1:0]  deriv_xi;
	logic signed [OUT_W-1:0]  deriv_eta;
	logic signed [OUT_W-1:0]  deriv_zeta;
	logic signed [DET_W-1:0]  jacobian_det;
	logic                     det_valid;

	modport source (output valid, result_node, shape_value, deriv_xi, deriv_eta,
		deriv_zeta, jacobian_det, det_valid, input ready);
	modport sink (input valid, result_node, shape_value, deriv_xi, deriv_eta,
		deriv_zeta, jacobian_det, det_valid, output ready);
endinterface

[rtl/core/hsj_mul.sv]
// Iterative signed multiplier for the determinant, one 8 bit digit per cycle.
// Depends on hsj_pkg for operand widths.
`timescale 1ns / 1ps

module hsj_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [hsj_pkg::MAW-1:0]    a,
	input  logic signed [hsj_pkg::MBW-1:0]    b,
	output logic                              done,
	output logic signed [hsj_pkg::MPW-1:0]    p
);
	import hsj_pkg::*;

	localparam int CW = $clog2(MSTEPS);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic              neg_q;
	logic [MPW-1:0]    ma_q;
	logic [MBW-1:0]    mb_q;
	logic [MPW-1:0]    acc_q;
	logic [MPW-1:0]    sum;
	logic signed [MPW-1:0] p_q;
	logic signed [MAW:0]   a_ext;
	logic signed [MBW:0]   b_ext;
	logic [MAW:0]      a_mag;
	logic [MBW:0]      b_mag;

	// magnitudes of the operands
	always_comb begin
		a_ext = (MAW+1)'(a);
		b_ext = (MBW+1)'(b);
		a_mag = a_ext[MAW] ? unsigned'(-a_ext) : unsigned'(a_ext);
		b_mag = b_ext[MBW] ? unsigned'(-b_ext) : unsigned'(b_ext);
	end

	// add one partial product
	assign sum = acc_q + MPW'(ma_q * mb_q[MDIG-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MSTEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand shift and accumulate
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[MAW-1] ^ b[MBW-1];
			ma_q  <= MPW'(a_mag);
			mb_q  <= b_mag[MBW-1:0];
			acc_q <= '0;
		end else if (busy_q) begin
			ma_q  <= ma_q << MDIG;
			mb_q  <= mb_q >> MDIG;
			acc_q <= sum;
			if (cnt_q == CW'(MSTEPS - 1))
				p_q <= neg_q ? -signed'(sum) : signed'(sum);
		end
	end

	assign done = done_q;
	assign p    = p_q;
endmodule

[rtl/core/hsj_datapath.sv]
// Datapath: shape factors, products, derivatives, Jacobian sums, determinant.
// Depends on hsj_pkg and hsj_mul; driven by hsj_ctrl through cmd_t.
`timescale 1ns / 1ps

module hsj_datapath #(
	parameter int POINT_FRAC_BITS = hsj_pkg::DEF_POINT_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hsj_pkg::cmd_t                       cmd,
	output hsj_pkg::status_t                    status,
	input  logic [hsj_pkg::NODE_W-1:0]          node_index,
	input  logic signed [hsj_pkg::PT_W-1:0]     point_xi,
	input  logic signed [hsj_pkg::PT_W-1:0]     point_eta,
	input  logic signed [hsj_pkg::PT_W-1:0]     point_zeta,
	input  logic signed [hsj_pkg::CRD_W-1:0]    node_x,
	input  logic signed [hsj_pkg::CRD_W-1:0]    node_y,
	input  logic signed [hsj_pkg::CRD_W-1:0]    node_z,
	output logic [hsj_pkg::NODE_W-1:0]          result_node,
	output logic signed [hsj_pkg::OUT_W-1:0]    shape_value,
	output logic signed [hsj_pkg::OUT_W-1:0]    deriv_xi,
	output logic signed [hsj_pkg::OUT_W-1:0]    deriv_eta,
	output logic signed [hsj_pkg::OUT_W-1:0]    deriv_zeta,
	output logic signed [hsj_pkg::DET_W-1:0]    jacobian_det,
	output logic                                det_valid
);
	import hsj_pkg::*;

	localparam int F    = POINT_FRAC_BITS;
	localparam int FMAX = (F > 15) ? F : 15;
	localparam int FW   = FMAX + 2;
	localparam int PW   = 2 * FW;
	localparam int HW   = PW - 16;
	localparam int DSH  = 2 * F - 13;
	localparam int SSH  = 3 * F - 13;
	localparam logic signed [FW-1:0] ONE = FW'(1) << F;

	// determinant step operations
	localparam logic [2:0] OP_MIN = 3'd0;  // hold first minor product
	localparam logic [2:0] OP_DIF = 3'd1;  // minor difference
	localparam logic [2:0] OP_SET = 3'd2;
	localparam logic [2:0] OP_SUB = 3'd3;
	localparam logic [2:0] OP_ADD = 3'd4;

	localparam logic signed [DET_W-1:0] DET_LIM = DET_W'(1) << (DET_W - 1);
	// magnitude limit 2^50 at the width of the whole-unit quotient
	localparam logic [ACCW-DET_FRAC-1:0] DET_CAP =
		(ACCW-DET_FRAC)'({1'b1, {(DET_W-1){1'b0}}});

	logic [NODE_W-1:0]        node_q;
	logic signed [CRD_W-1:0]  crd_q [3];
	logic signed [FW-1:0]     f_q [3];
	logic signed [PW-1:0]     p01_q, p12_q, p02_q;
	logic signed [OUT_W-1:0]  d_q [3];
	logic signed [16+FW:0]    shlo_q;
	logic signed [HW+FW-1:0]  shhi_q;
	logic signed [OUT_W-1:0]  shape_q;
	logic signed [JW-1:0]     jac_q [9];
	logic signed [MAW-1:0]    m_q, c_q;
	logic signed [ACCW-1:0]   acc_q;
	logic signed [DET_W-1:0]  det_q;

	logic [2:0] plus_in, plus_q;
	logic [2:0] op;
	logic       a_is_c;
	logic [3:0] a_idx, b_idx;
	logic signed [MAW-1:0] mul_a;
	logic signed [MBW-1:0] mul_b;
	logic                  mul_done;
	logic signed [MPW-1:0] mul_p;
	logic signed [PW:0]    dv [3];
	logic signed [PW-1:0]  dp [3];
	logic signed [79:0]    shape_full;
	logic [ACCW-1:0]       det_mag;
	logic [ACCW-DET_FRAC-1:0] det_qf;

	// side of each axis for a corner
	assign plus_in = {node_index[2], node_index[1], node_index[0] ^ node_index[1]};
	assign plus_q  = {node_q[2], node_q[1], node_q[0] ^ node_q[1]};

	// latch request and form the linear factors
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			node_q   <= node_index;
			crd_q[0] <= node_x;
			crd_q[1] <= node_y;
			crd_q[2] <= node_z;
			f_q[0]   <= plus_in[0] ? ONE + FW'(point_xi)   : ONE - FW'(point_xi);
			f_q[1]   <= plus_in[1] ? ONE + FW'(point_eta)  : ONE - FW'(point_eta);
			f_q[2]   <= plus_in[2] ? ONE + FW'(point_zeta) : ONE - FW'(point_zeta);
		end
	end

	// pairwise factor products
	always_ff @(posedge clk) begin
		if (cmd.prod) begin
			p01_q <= f_q[0] * f_q[1];
			p12_q <= f_q[1] * f_q[2];
			p02_q <= f_q[0] * f_q[2];
		end
	end

	// derivatives: signed pair product, floor shift, clamp
	assign dp[0] = p12_q;
	assign dp[1] = p02_q;
	assign dp[2] = p01_q;
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dv[a] = plus_q[a] ? (PW+1)'(dp[a]) : -((PW+1)'(dp[a]));
			dv[a] = dv[a] >>> DSH;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deriv) begin
			for (int a = 0; a < 3; a++)
				d_q[a] <= sat18(80'(dv[a]));
			shlo_q <= $signed({1'b0, p01_q[15:0]}) * f_q[2];
			shhi_q <= HW'(p01_q >>> 16) * f_q[2];
		end
	end

	// rejoin the split shape product
	assign shape_full = (80'(shhi_q) <<< 16) + 80'(shlo_q);

	// shape clamp and Jacobian accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < 9; e++)
				jac_q[e] <= '0;
		end else if (cmd.jac) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					jac_q[r*3+c] <= ((node_q == '0) ? JW'(0) : jac_q[r*3+c]) +
						JW'(d_q[c] * crd_q[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.jac)
			shape_q <= sat18(shape_full >>> SSH);
	end

	// determinant by cofactors along the first row
	always_comb begin
		a_is_c = 1'b0;
		a_idx  = 4'd0;
		b_idx  = 4'd0;
		op     = OP_MIN;
		unique case (cmd.det_step)
			4'd0: begin a_idx = 4'd4; b_idx = 4'd8; op = OP_MIN; end
			4'd1: begin a_idx = 4'd5; b_idx = 4'd7; op = OP_DIF; end
			4'd2: begin a_is_c = 1'b1; b_idx = 4'd0; op = OP_SET; end
			4'd3: begin a_idx = 4'd3; b_idx = 4'd8; op = OP_MIN; end
			4'd4: begin a_idx = 4'd5; b_idx = 4'd6; op = OP_DIF; end
			4'd5: begin a_is_c = 1'b1; b_idx = 4'd1; op = OP_SUB; end
			4'd6: begin a_idx = 4'd3; b_idx = 4'd7; op = OP_MIN; end
			4'd7: begin a_idx = 4'd4; b_idx = 4'd6; op = OP_DIF; end
			4'd8: begin a_is_c = 1'b1; b_idx = 4'd2; op = OP_ADD; end
			default: begin a_idx = 4'd0; b_idx = 4'd0; op = OP_MIN; end
		endcase
	end

	assign mul_a = a_is_c ? c_q : MAW'(jac_q[a_idx]);
	assign mul_b = jac_q[b_idx];

	hsj_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.det_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	// fold each product into minor or sum
	always_ff @(posedge clk) begin
		if (cmd.det_apply) begin
			unique case (op)
				OP_MIN:  m_q   <= MAW'(mul_p);
				OP_DIF:  c_q   <= m_q - MAW'(mul_p);
				OP_SET:  acc_q <= ACCW'(mul_p);
				OP_SUB:  acc_q <= acc_q - ACCW'(mul_p);
				OP_ADD:  acc_q <= acc_q + ACCW'(mul_p);
				default: m_q   <= MAW'(mul_p);
			endcase
		end
	end

	// truncate toward zero and clamp
	assign det_mag = acc_q[ACCW-1] ? unsigned'(-acc_q) : unsigned'(acc_q);
	assign det_qf  = det_mag[ACCW-1:DET_FRAC];

	always_ff @(posedge clk) begin
		if (cmd.det_fin) begin
			if (acc_q[ACCW-1])
				det_q <= (det_qf >= DET_CAP) ?
					DET_LIM : -signed'(DET_W'(det_qf));
			else
				det_q <= (det_qf >= DET_CAP) ?
					~DET_LIM : signed'(DET_W'(det_qf));
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_node  <= node_q;
			shape_value  <= shape_q;
			deriv_xi     <= d_q[0];
			deriv_eta    <= d_q[1];
			deriv_zeta   <= d_q[2];
			det_valid    <= (node_q == 3'd7);
			jacobian_det <= (node_q == 3'd7) ? det_q : '0;
		end
	end

	assign status.node7    = (node_q == 3'd7);
	assign status.mul_done = mul_done;
endmodule

[rtl/core/hsj_ctrl.sv]
// Controller: sequences one node through the datapath and runs the
// determinant steps on corner 7. Depends on hsj_pkg.
`timescale 1ns / 1ps

module hsj_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  hsj_pkg::status_t   status,
	output hsj_pkg::cmd_t      cmd
);
	import hsj_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PRD  = 3'd1;
	localparam logic [2:0] ST_DRV  = 3'd2;
	localparam logic [2:0] ST_JAC  = 3'd3;
	localparam logic [2:0] ST_DST  = 3'd4;
	localparam logic [2:0] ST_DWT  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		cmd.det_step = step_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_PRD;
				end
			end
			ST_PRD: begin
				cmd.prod = 1'b1;
				state_d  = ST_DRV;
			end
			ST_DRV: begin
				cmd.deriv = 1'b1;
				state_d   = ST_JAC;
			end
			ST_JAC: begin
				cmd.jac = 1'b1;
				step_d  = '0;
				state_d = status.node7 ? ST_DST : ST_OUT;
			end
			ST_DST: begin
				cmd.det_start = 1'b1;
				state_d       = ST_DWT;
			end
			ST_DWT: begin
				if (status.mul_done) begin
					cmd.det_apply = 1'b1;
					if (step_q == STEP_W'(DET_STEPS - 1)) begin
						state_d = ST_FIN;
					end else begin
						step_d  = step_q + 1'b1;
						state_d = ST_DST;
					end
				end
			end
			ST_FIN: begin
				cmd.det_fin = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			// hold result until taken
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end
endmodule

[rtl/core/hex8_shape_jacobian.sv]
// Top level of the trilinear hexahedron shape function and Jacobian block.
// Depends on hsj_pkg, hsj_in_if, hsj_out_if, hsj_ctrl, hsj_datapath.
//
// Usage:
//   Send the eight corners of an element on "item", one request each, in
//   standard corner order; corner 0 restarts the Jacobian sums. Each request
//   returns one result on "result": the corner's shape value and its three
//   natural derivatives, scaled by 2^16 and clamped to 18 bits. The result
//   for corner 7 also carries the Jacobian determinant with det_valid set.
//   The controller steps each request through the factor, product,
//   derivative and accumulate stages into the result register; for corner 7
//   the determinant first takes nine passes of the digit-serial multiplier,
//   each folded into the minor or sum, and a final truncate-and-clamp step.
//   It works on one item at a time and takes the next request only once
//   the last result is loaded into the output register and it is back in idle.
//   A finished result waits in the output register; the next request is
//   taken and worked on meanwhile and holds in its last stage if the
//   receiver still stalls. Reset clears the sums and drops any result.
`timescale 1ns / 1ps

module hex8_shape_jacobian #(
	parameter int POINT_FRAC_BITS = hsj_pkg::DEF_POINT_FRAC_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	hsj_in_if.sink     item,
	hsj_out_if.source  result
);
	import hsj_pkg::*;

	cmd_t    cmd;
	status_t status;

	hsj_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	hsj_datapath #(
		.POINT_FRAC_BITS (POINT_FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.node_index   (item.node_index),
		.point_xi     (item.point_xi),
		.point_eta    (item.point_eta),
		.point_zeta   (item.point_zeta),
		.node_x       (item.node_x),
		.node_y       (item.node_y),
		.node_z       (item.node_z),
		.result_node  (result.result_node),
		.shape_value  (result.shape_value),
		.deriv_xi     (result.deriv_xi),
		.deriv_eta    (result.deriv_eta),
		.deriv_zeta   (result.deriv_zeta),
		.jacobian_det (result.jacobian_det),
		.det_valid    (result.det_valid)
	);
endmodule

[bench/hex8_shape_jacobian_checker.sv]
// Checker for the hexahedron shape function block: watches both channels,
// predicts each result and compares it field by field. Depends on hsj_pkg and the interfaces.
`timescale 1ns / 1ps

module hex8_shape_jacobian_checker #(
	parameter int POINT_FRAC_BITS = hsj_pkg::DEF_POINT_FRAC_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	hsj_in_if.sink     item,
	hsj_out_if.sink    result,
	output int         fail_count,
	output int         pending_count
);
	import hsj_pkg::*;

	typedef struct packed {
		logic [NODE_W-1:0]       node;
		logic signed [OUT_W-1:0] shape;
		logic signed [OUT_W-1:0] dxi;
		logic signed [OUT_W-1:0] deta;
		logic signed [OUT_W-1:0] dzeta;
		logic signed [DET_W-1:0] det;
		logic                    det_ok;
	} shape_res_t;

	shape_res_t      expected_shapes[$];
	logic [JW-1:0]   jac_model[9];

	assign pending_count = expected_shapes.size();

	// floor shift and clamp to the output range
	function automatic logic signed [OUT_W-1:0] clamp_shift(longint v, int s);
		longint r;
		r = v >>> s;
		if (r > 131071) r = 131071;
		else if (r < -131072) r = -131072;
		return r[OUT_W-1:0];
	endfunction

	// exact determinant, truncated toward zero and clamped
	function automatic logic signed [DET_W-1:0] jac_determinant();
		logic signed [127:0] e[9];
		logic signed [127:0] acc;
		logic [127:0] mag;
		logic [127:0] q;
		for (int i = 0; i < 9; i++)
			e[i] = {{88{jac_model[i][JW-1]}}, jac_model[i]};
		acc = e[0]*e[4]*e[8] - e[0]*e[5]*e[7] - e[1]*e[3]*e[8]
			+ e[1]*e[5]*e[6] + e[2]*e[3]*e[7] - e[2]*e[4]*e[6];
		mag = acc[127] ? -acc : acc;
		q = mag >> 48;
		if (q > (128'd1 << 50)) q = 128'd1 << 50;
		if (acc[127]) return -$signed({1'b0, q[DET_W-1:0]});
		if (q > (128'd1 << 50) - 1) q = (128'd1 << 50) - 1;
		return q[DET_W-1:0];
	endfunction

	// compute the expected result for one node request and update the sums
	function automatic shape_res_t predict_node(logic [2:0] nd, longint p[3], longint crd[3]);
		shape_res_t r;
		longint one, f[3], prod, d[3];
		logic plus[3];
		one = longint'(1) << POINT_FRAC_BITS;
		plus[0] = (nd == 1 || nd == 2 || nd == 5 || nd == 6);
		plus[1] = nd[1];
		plus[2] = nd[2];
		for (int a = 0; a < 3; a++) f[a] = plus[a] ? one + p[a] : one - p[a];
		r.node = nd;
		r.shape = clamp_shift(f[0]*f[1]*f[2], 3*POINT_FRAC_BITS - 13);
		for (int a = 0; a < 3; a++) begin
			prod = f[(a+1)%3] * f[(a+2)%3];
			if (!plus[a]) prod = -prod;
			d[a] = clamp_shift(prod, 2*POINT_FRAC_BITS - 13);
		end
		r.dxi = d[0];
		r.deta = d[1];
		r.dzeta = d[2];
		for (int rr = 0; rr < 3; rr++)
			for (int c = 0; c < 3; c++)
				jac_model[rr*3+c] = ((nd == 0) ? JW'(0) : jac_model[rr*3+c])
					+ JW'(d[c] * crd[rr]);
		r.det_ok = (nd == 7);
		r.det = r.det_ok ? jac_determinant() : '0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint p[3], crd[3];
		shape_res_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) jac_model[i] = '0;
			expected_shapes.delete();
			fail_count = 0;
		end else begin
			// compare an accepted result with the oldest prediction
			if (result.valid && result.ready) begin
				if (expected_shapes.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					exp_r = expected_shapes.pop_front();
					if (result.result_node !== exp_r.node) begin
						$error("result_node exp %0d got %0d", exp_r.node, result.result_node);
						fail_count++;
					end
					if (result.shape_value !== exp_r.shape) begin
						$error("shape_value exp %0d got %0d", exp_r.shape, result.shape_value);
						fail_count++;
					end
					if (result.deriv_xi !== exp_r.dxi) begin
						$error("deriv_xi exp %0d got %0d", exp_r.dxi, result.deriv_xi);
						fail_count++;
					end
					if (result.deriv_eta !== exp_r.deta) begin
						$error("deriv_eta exp %0d got %0d", exp_r.deta, result.deriv_eta);
						fail_count++;
					end
					if (result.deriv_zeta !== exp_r.dzeta) begin
						$error("deriv_zeta exp %0d got %0d", exp_r.dzeta, result.deriv_zeta);
						fail_count++;
					end
					if (result.jacobian_det !== exp_r.det) begin
						$error("jacobian_det exp %0d got %0d", exp_r.det, result.jacobian_det);
						fail_count++;
					end
					if (result.det_valid !== exp_r.det_ok) begin
						$error("det_valid exp %0d got %0d", exp_r.det_ok, result.det_valid);
						fail_count++;
					end
				end
			end
			// predict each accepted request
			if (item.valid && item.ready) begin
				p[0] = item.point_xi;
				p[1] = item.point_eta;
				p[2] = item.point_zeta;
				crd[0] = item.node_x;
				crd[1] = item.node_y;
				crd[2] = item.node_z;
				expected_shapes.push_back(predict_node(item.node_index, p, crd));
			end
		end
	end
endmodule

[bench/hex8_shape_jacobian_test.sv]
// Testbench top for hex8_shape_jacobian: drives node requests and result stalls,
// gives the verdict. Depends on hsj_pkg, the interfaces and the checker.
`timescale 1ns / 1ps

module hex8_shape_jacobian_test;
	import hsj_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending_count;
	int   cycle_count = 0;
	int   calm_start;

	hsj_in_if  item_ch();
	hsj_out_if result_ch();

	hex8_shape_jacobian u_dut (.clk(clk), .arst_n(arst_n), .item(item_ch.sink),
		.result(result_ch.source));

	hex8_shape_jacobian_checker u_checker (.clk(clk), .arst_n(arst_n),
		.item(item_ch.sink), .result(result_ch.sink),
		.fail_count(fail_count), .pending_count(pending_count));

	always #1 clk = ~clk;

	initial begin
		item_ch.valid = 1'b0;
		item_ch.node_index = '0;
		item_ch.point_xi = '0;
		item_ch.point_eta = '0;
		item_ch.point_zeta = '0;
		item_ch.node_x = '0;
		item_ch.node_y = '0;
		item_ch.node_z = '0;
		result_ch.ready = 1'b0;
		calm_start = $urandom_range(200, 600);
	end

	// stall the receiver at random, except in a quiet stretch
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (!arst_n) result_ch.ready <= 1'b0;
		else if (cycle_count >= calm_start && cycle_count < calm_start + 1500)
			result_ch.ready <= 1'b1;
		else result_ch.ready <= ($urandom_range(0, 99) >= 18);
	end

	// timeout
	always @(posedge clk) begin
		if (cycle_count > 400000) begin
			$display("** hex8_shape_jacobian: FAILED **");
			$finish;
		end
	end

	// point coordinate: mostly in range, sometimes any 16 bit value
	function automatic logic [PT_W-1:0] rand_point();
		case ($urandom_range(0, 9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return PT_W'($urandom());
			default: return PT_W'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	function automatic logic [CRD_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return CRD_W'($urandom());
			default: return CRD_W'($urandom_range(0, 400) - 200);
		endcase
	endfunction

	// send one node request and hold it until accepted
	task automatic send_node(logic [2:0] nd, logic [15:0] xi, logic [15:0] eta,
		logic [15:0] zeta, logic [15:0] x, logic [15:0] y, logic [15:0] z, bit gaps);
		while (gaps && !(cycle_count >= calm_start && cycle_count < calm_start + 1500)
			&& $urandom_range(0, 99) < 18) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.node_index <= nd;
		item_ch.point_xi <= xi;
		item_ch.point_eta <= eta;
		item_ch.point_zeta <= zeta;
		item_ch.node_x <= x;
		item_ch.node_y <= y;
		item_ch.node_z <= z;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	initial begin
		logic [15:0] xi, eta, zeta;
		int lim;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: corners before any restart, extreme points and coordinates
		send_node(3'd3, 16'sd16384, -16'sd16384, 16'sd0, 16'h7fff, 16'h8000, 16'd5, 1'b0);
		send_node(3'd7, 16'h7fff, 16'h8000, 16'hffff, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
		for (int n = 0; n < 8; n++)
			send_node(n[2:0], 16'sd0, 16'sd0, 16'sd0,
				{15'd0, n[0]} * 16'd100, {15'd0, n[1]} * 16'd100, {15'd0, n[2]} * 16'd100,
				1'b0);
		for (int n = 0; n < 8; n++)
			send_node(n[2:0], 16'h8000, 16'h7fff, 16'h8000,
				n[0] ? 16'h7fff : 16'h8000, n[1] ? 16'h8000 : 16'h7fff, 16'h7fff, 1'b0);
		send_node(3'd0, 16'sd16384, 16'sd16384, 16'sd16384, 16'd1, 16'd2, 16'd3, 1'b0);
		send_node(3'd7, -16'sd16384, -16'sd16384, -16'sd16384, 16'd1, 16'd2, 16'd3, 1'b0);
		// random: mostly whole elements, some broken or repeated sequences
		lim = 0;
		while (lim < 1100) begin
			xi = rand_point();
			eta = rand_point();
			zeta = rand_point();
			if ($urandom_range(0, 9) < 8) begin
				for (int n = 0; n < 8; n++)
					send_node(n[2:0], xi, eta, zeta, rand_coord(), rand_coord(),
						rand_coord(), 1'b1);
				lim += 8;
			end else begin
				send_node(NODE_W'($urandom_range(0, 7)), rand_point(), rand_point(),
					rand_point(), rand_coord(), rand_coord(), rand_coord(), 1'b1);
				lim++;
			end
		end
		item_ch.valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) $display("** hex8_shape_jacobian: PASSED **");
		else $display("** hex8_shape_jacobian: FAILED **");
		$finish;
	end
endmodule

[filelist.f]
rtl/core/hsj_pkg.sv
rtl/core/hsj_in_if.sv
rtl/core/hsj_out_if.sv
rtl/core/hsj_mul.sv
rtl/core/hsj_datapath.sv
rtl/core/hsj_ctrl.sv
rtl/core/hex8_shape_jacobian.sv
bench/hex8_shape_jacobian_checker.sv
bench/hex8_shape_jacobian_test.sv
